/* hdl/aabbct_pkg.sv */
// Shared types, codes and offset helpers for the box collision table.
package aabbct_pkg;

    // Command codes carried by one input word.
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_TEST  = 2'd2
    } t_cmd;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ALLOC_OK = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_FREED    = 3'd2,
        KIND_BOX_HIT  = 3'd3,
        KIND_REF_HIT  = 3'd4,
        KIND_NO_HIT   = 3'd5
    } t_kind;

    // Table select.
    localparam logic TBL_SPARE = 1'b0;
    localparam logic TBL_BOX   = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_TEST,
        S_TEST_END,
        S_REPORT
    } t_state;

    // One entry of the checked-box table.
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic        handler;
    } t_box;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_go;
        logic test_go;
        logic clr_go;
        logic alloc_hit;
        logic alloc_full;
        logic free_exec;
        logic load_res;
        logic load_final;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic addr_last;
        logic rd_vld;
        logic rd_free;
        logic scan_end;
        logic out_free;
    } t_dp_stat;

    // Edge difference truncated to 8 bits.
    function automatic logic signed [7:0] f_diff(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        return $signed(a[7:0] - b[7:0]);
    endfunction

    // Halve, rounding toward zero.
    function automatic logic signed [7:0] f_half(input logic signed [7:0] v);
        logic signed [7:0] t;
        t = v[7] ? (v + 8'sd1) : v;
        return t >>> 1;
    endfunction

    // Contact offset on one axis, seen from the box or from the reference.
    function automatic logic signed [7:0] f_offset(input logic signed [15:0] bl,
                                                   input logic signed [15:0] br,
                                                   input logic signed [15:0] rl,
                                                   input logic signed [15:0] rr,
                                                   input logic from_ref);
        logic cl;
        logic cr;
        logic signed [7:0] res;
        cl = (bl <= rl);   // overlap starts at the reference edge
        cr = (br >= rr);   // overlap ends at the reference edge
        if (!cl && !cr) begin
            res = f_half(f_diff(br, bl));
        end else if (!from_ref) begin
            if (cl && cr) begin
                res = f_half(f_diff(br, bl));
            end else if (cl) begin
                res = f_diff(rl, bl);
            end else begin
                res = f_diff(rr, bl);
            end
        end else begin
            if (cl && cr) begin
                res = f_half(f_diff(rr, rl));
            end else if (cl) begin
                res = f_diff(br, rl);
            end else begin
                res = f_diff(bl, rl);
            end
        end
        return res;
    endfunction

endpackage

/* hdl/aabbct_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module aabbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/aabbct_ctrl.sv */
// Controller state machine: sequences clear, allocate, free and test.
module aabbct_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_command,
    input  aabbct_pkg::t_dp_stat i_stat,
    output aabbct_pkg::t_dp_cmd  o_cmd,
    output logic                 o_stall
);
    import aabbct_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_dp_cmd  cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_go = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    case (t_cmd'(i_command))
                        CMD_ALLOC: begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_ALLOC;
                        end
                        CMD_FREE: begin
                            n_state = S_FREE;
                        end
                        CMD_TEST: begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_TEST;
                        end
                        default: begin
                            n_state = S_IDLE;   // unknown command is dropped
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (i_stat.scan_end) begin
                    cmd.alloc_full = 1'b1;
                    n_state        = S_REPORT;
                end else begin
                    cmd.scan_go = 1'b1;
                    if (i_stat.rd_vld && i_stat.rd_free) begin
                        cmd.alloc_hit = 1'b1;
                        n_state       = S_REPORT;
                    end
                end
            end
            S_FREE: begin
                cmd.free_exec = 1'b1;
                n_state       = S_REPORT;
            end
            S_TEST: begin
                if (i_stat.scan_end) begin
                    n_state = S_TEST_END;
                end else begin
                    cmd.scan_go = i_stat.out_free;
                    cmd.test_go = i_stat.out_free;
                end
            end
            S_TEST_END: begin
                if (i_stat.out_free) begin
                    cmd.load_final = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    cmd.load_res = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

endmodule

/* hdl/aabbct_dp.sv */
// Datapath: box and spare tables, slot scanner, overlap test, result register.
module aabbct_dp #(
    parameter int SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aabbct_pkg::t_dp_cmd  i_cmd,
    output aabbct_pkg::t_dp_stat o_stat,
    input  logic                 i_table_sel,
    input  logic [5:0]           i_slot,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [14:0]          i_size_w,
    input  logic [14:0]          i_size_h,
    input  logic signed [15:0]   i_edge_right,
    input  logic signed [15:0]   i_edge_bottom,
    input  logic                 i_box_handler,
    input  logic                 i_ref_handler,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [2:0]           o_kind,
    output logic [5:0]           o_slot_index,
    output logic signed [7:0]    o_offset_x,
    output logic signed [7:0]    o_offset_y,
    output logic                 o_last
);
    import aabbct_pkg::*;

    localparam int              AW        = $clog2(SLOTS);
    localparam int              BW        = $bits(t_box);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(SLOTS - 1);

    // captured word
    logic                r_sel;
    logic [5:0]          r_slot;
    logic signed [15:0]  r_pos_x;
    logic signed [15:0]  r_pos_y;
    logic [15:0]         r_new_r;
    logic [15:0]         r_new_b;
    logic                r_box_h;
    logic signed [15:0]  r_ref_r;
    logic signed [15:0]  r_ref_b;
    logic                r_ref_h;

    // scanner
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_rd_addr;
    logic                r_issue_done;
    logic                r_rd_vld;
    logic                issue;

    // single result and pending hit
    t_kind               r_res_kind;
    logic [5:0]          r_res_slot;
    logic                r_pend_vld;
    t_kind               r_pend_kind;
    logic [5:0]          r_pend_slot;
    logic signed [7:0]   r_pend_ox;
    logic signed [7:0]   r_pend_oy;

    // output register
    logic                r_o_valid;
    t_kind               r_o_kind;
    logic [5:0]          r_o_slot;
    logic signed [7:0]   r_o_ox;
    logic signed [7:0]   r_o_oy;
    logic                r_o_last;

    // memories
    logic                box_we;
    logic                spare_we;
    logic [AW-1:0]       waddr;
    logic [BW-1:0]       box_wdata;
    logic [BW-1:0]       box_rdata;
    logic                spare_wdata;
    logic                spare_rdata;
    t_box                rd_box;
    t_box                new_box;

    logic [15:0]         slot_ext;
    logic [15:0]         rd_addr_ext;
    logic                in_range;
    logic                rd_free;
    logic                out_free;
    logic                hit;
    logic                has_res;
    logic                from_ref;
    logic signed [15:0]  bl;
    logic signed [15:0]  bt;
    logic signed [15:0]  br;
    logic signed [15:0]  bb;
    logic signed [7:0]   hit_ox;
    logic signed [7:0]   hit_oy;
    t_kind               hit_kind;
    logic                push_pend;

    assign slot_ext    = 16'(r_slot);
    assign rd_addr_ext = 16'(r_rd_addr);
    assign in_range    = (slot_ext < 16'(SLOTS));
    assign out_free    = !r_o_valid || !i_stall;
    assign issue       = i_cmd.scan_go && !r_issue_done;

    // ---- capture ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sel   <= i_table_sel;
            r_slot  <= i_slot;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_new_r <= i_pos_x + {1'b0, i_size_w};
            r_new_b <= i_pos_y + {1'b0, i_size_h};
            r_box_h <= i_box_handler;
            r_ref_r <= i_edge_right;
            r_ref_b <= i_edge_bottom;
            r_ref_h <= i_ref_handler;
        end
    end

    // ---- scanner and clear counter ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (i_cmd.clr_go || issue) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            if (issue && r_addr == LAST_ADDR) begin
                r_issue_done <= 1'b1;
            end
            if (i_cmd.scan_go) begin
                r_rd_vld <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_addr <= r_addr;
        end
    end

    // ---- tables ----
    assign new_box = '{left: r_pos_x, top: r_pos_y, right: r_new_r,
                       bottom: r_new_b, handler: r_box_h};

    assign box_we      = i_cmd.clr_go
                       || (i_cmd.alloc_hit && r_sel == TBL_BOX)
                       || (i_cmd.free_exec && r_sel == TBL_BOX && in_range);
    assign spare_we    = i_cmd.clr_go
                       || (i_cmd.alloc_hit && r_sel == TBL_SPARE)
                       || (i_cmd.free_exec && r_sel == TBL_SPARE && in_range);
    assign waddr       = i_cmd.clr_go    ? r_addr
                       : i_cmd.alloc_hit ? r_rd_addr
                       :                   slot_ext[AW-1:0];
    assign box_wdata   = i_cmd.alloc_hit ? BW'(new_box) : '0;
    assign spare_wdata = i_cmd.alloc_hit && ((r_new_r != '0) || (r_new_b != '0));

    aabbct_ram #(
        .WIDTH (BW),
        .DEPTH (SLOTS)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (box_we),
        .i_waddr (waddr),
        .i_wdata (box_wdata),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (box_rdata)
    );

    aabbct_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_spare_ram (
        .i_clk   (i_clk),
        .i_we    (spare_we),
        .i_waddr (waddr),
        .i_wdata (spare_wdata),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (spare_rdata)
    );

    assign rd_box  = t_box'(box_rdata);
    assign rd_free = (r_sel == TBL_BOX) ? (rd_box.right == '0 && rd_box.bottom == '0)
                                        : !spare_rdata;

    // ---- overlap test on the entry just read ----
    assign bl = $signed(rd_box.left);
    assign bt = $signed(rd_box.top);
    assign br = $signed(rd_box.right);
    assign bb = $signed(rd_box.bottom);

    assign hit      = (br >= r_pos_x) && (bb >= r_pos_y) && (bl < r_ref_r) && (bt < r_ref_b);
    assign from_ref = !rd_box.handler;
    assign has_res  = r_rd_vld && hit && (rd_box.handler || r_ref_h);
    assign hit_kind = rd_box.handler ? KIND_BOX_HIT : KIND_REF_HIT;
    assign hit_ox   = f_offset(bl, br, r_pos_x, r_ref_r, from_ref);
    assign hit_oy   = f_offset(bt, bb, r_pos_y, r_ref_b, from_ref);

    // a new hit pushes the one held back out; the held one is last only at scan end
    assign push_pend = i_cmd.test_go && has_res && r_pend_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.test_go && has_res) begin
            r_pend_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test_go && has_res) begin
            r_pend_kind <= hit_kind;
            r_pend_slot <= rd_addr_ext[5:0];
            r_pend_ox   <= hit_ox;
            r_pend_oy   <= hit_oy;
        end
        if (i_cmd.alloc_hit) begin
            r_res_kind <= KIND_ALLOC_OK;
            r_res_slot <= rd_addr_ext[5:0];
        end else if (i_cmd.alloc_full) begin
            r_res_kind <= KIND_FULL;
            r_res_slot <= '0;
        end else if (i_cmd.free_exec) begin
            r_res_kind <= KIND_FREED;
            r_res_slot <= r_slot;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_res || i_cmd.load_final || push_pend) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_o_kind <= r_res_kind;
            r_o_slot <= r_res_slot;
            r_o_ox   <= '0;
            r_o_oy   <= '0;
            r_o_last <= 1'b1;
        end else if (push_pend || (i_cmd.load_final && r_pend_vld)) begin
            r_o_kind <= r_pend_kind;
            r_o_slot <= r_pend_slot;
            r_o_ox   <= r_pend_ox;
            r_o_oy   <= r_pend_oy;
            r_o_last <= i_cmd.load_final;
        end else if (i_cmd.load_final) begin
            r_o_kind <= KIND_NO_HIT;
            r_o_slot <= '0;
            r_o_ox   <= '0;
            r_o_oy   <= '0;
            r_o_last <= 1'b1;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_slot_index = r_o_slot;
    assign o_offset_x   = r_o_ox;
    assign o_offset_y   = r_o_oy;
    assign o_last       = r_o_last;

    assign o_stat = '{addr_last: (r_addr == LAST_ADDR),
                      rd_vld:    r_rd_vld,
                      rd_free:   rd_free,
                      scan_end:  r_issue_done && !r_rd_vld,
                      out_free:  out_free};

    // ---- checks ----
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_res || i_cmd.load_final || push_pend) |-> out_free)
        else $error("result word loaded over one not yet taken");

    a_scan_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_start |=> (!r_pend_vld && !r_rd_vld && !r_issue_done))
        else $error("scan started with stale state");

    a_alloc_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_hit |-> (r_rd_vld && rd_free))
        else $error("allocation into a slot not read as free");

    a_final_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_final |-> (r_issue_done && !r_rd_vld))
        else $error("final test word before scan finished");

endmodule

/* hdl/aabb_collision_table.sv */
// Top level of the box collision table: controller plus datapath.
//
// Keeps SLOTS checked boxes (left, top, right, bottom, handler flag) and SLOTS
// unchecked slot marks. Each input word carries one command. Allocate scans
// the chosen table from slot 0 for the first free slot (a box is free when
// right and bottom are both zero) and returns one word, alloc ok or table
// full. Free clears one slot and returns one word. Test compares the reference
// box with every checked slot, free ones included, and returns one word per
// hit that has a handler on the box or on the reference, with 8-bit contact
// offsets; o_last marks the final word, and a test with no such hit returns a
// single no-hit word. Command code 3 is dropped without a result.
// Timing: the box and mark tables sit in RAMs with one read port, and the
// scanner reads one slot per cycle, except that a test holds its scan while
// the output register holds a word that the output side stalls. A new word
// is taken only once the previous command has its last result in the output
// register, which then drains while the next command runs. After reset a
// clearing pass over every slot zeroes both tables; o_stall stays high
// through it. slot_index carries the low 6 bits of the slot number.
module aabb_collision_table #(
    parameter int SLOTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic               i_table_sel,
    input  logic [5:0]         i_slot,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0]        i_size_w,
    input  logic [14:0]        i_size_h,
    input  logic signed [15:0] i_edge_right,
    input  logic signed [15:0] i_edge_bottom,
    input  logic               i_box_handler,
    input  logic               i_ref_handler,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_kind,
    output logic [5:0]         o_slot_index,
    output logic signed [7:0]  o_offset_x,
    output logic signed [7:0]  o_offset_y,
    output logic               o_last
);
    import aabbct_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    aabbct_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_stall   (o_stall)
    );

    // tables, scanner, overlap logic and output word register
    aabbct_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_table_sel   (i_table_sel),
        .i_slot        (i_slot),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_size_w      (i_size_w),
        .i_size_h      (i_size_h),
        .i_edge_right  (i_edge_right),
        .i_edge_bottom (i_edge_bottom),
        .i_box_handler (i_box_handler),
        .i_ref_handler (i_ref_handler),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_slot_index  (o_slot_index),
        .o_offset_x    (o_offset_x),
        .o_offset_y    (o_offset_y),
        .o_last        (o_last)
    );

endmodule

/* test/aabb_collision_table_test.sv */
// Self-checking testbench for aabb_collision_table: directed table, then random commands.
module aabb_collision_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aabbct_pkg::*;

    localparam int SLOTS          = 64;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_WORDS   = 385;
    localparam int FILL_WORDS     = 190;     // alloc-heavy stretch, drives both tables full
    localparam int STEADY_FROM    = 325;     // no idling on either side from here on
    localparam int HOLD_AT        = 80;      // random word index where the long hold-off starts
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 3000;    // cycles without any handshake
    localparam int MAX_REPORTS    = 10;
    localparam int PREDICTED      = -1;      // directed row checked against the predictor
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One command word as driven on the input ports.
    typedef struct {
        logic [1:0]         command;
        logic               sel;
        logic [5:0]         slot;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
        logic signed [15:0] er;
        logic signed [15:0] eb;
        logic               bh;
        logic               rh;
    } cmd_word_t;

    // One result word as seen on the output ports.
    typedef struct {
        logic [2:0]        kind;
        logic [5:0]        slot;
        logic signed [7:0] ox;
        logic signed [7:0] oy;
        logic              last;
    } result_t;

    // Directed row: a command plus, where obvious, the single result it must give.
    typedef struct {
        cmd_word_t  cw;
        bit         typed;
        logic [2:0] kind;
        logic [5:0] slot;
    } plan_row_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [1:0]         i_command     = '0;
    logic               i_table_sel   = 1'b0;
    logic [5:0]         i_slot        = '0;
    logic signed [15:0] i_pos_x       = '0;
    logic signed [15:0] i_pos_y       = '0;
    logic [14:0]        i_size_w      = '0;
    logic [14:0]        i_size_h      = '0;
    logic signed [15:0] i_edge_right  = '0;
    logic signed [15:0] i_edge_bottom = '0;
    logic               i_box_handler = 1'b0;
    logic               i_ref_handler = 1'b0;
    logic               i_stall       = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [2:0]         o_kind;
    logic [5:0]         o_slot_index;
    logic signed [7:0]  o_offset_x;
    logic signed [7:0]  o_offset_y;
    logic               o_last;

    // Shadow copy of the block's tables, kept by the predictor.
    logic [15:0] box_l [SLOTS] = '{default: '0};
    logic [15:0] box_t [SLOTS] = '{default: '0};
    logic [15:0] box_r [SLOTS] = '{default: '0};
    logic [15:0] box_b [SLOTS] = '{default: '0};
    bit          box_h [SLOTS] = '{default: 1'b0};
    bit          mark_used [SLOTS] = '{default: 1'b0};

    plan_row_t plan[$];
    result_t   scan_results[$];      // words produced by the command just accepted
    result_t   awaited_words[$];     // words the block still owes, oldest first
    int        fail_count   = 0;
    int        stuck_cycles = 0;
    bit        hold_req     = 1'b0;
    bit        steady_phase = 1'b0;

    aabb_collision_table #(.SLOTS(SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_table_sel   (i_table_sel),
        .i_slot        (i_slot),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_size_w      (i_size_w),
        .i_size_h      (i_size_h),
        .i_edge_right  (i_edge_right),
        .i_edge_bottom (i_edge_bottom),
        .i_box_handler (i_box_handler),
        .i_ref_handler (i_ref_handler),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_slot_index  (o_slot_index),
        .o_offset_x    (o_offset_x),
        .o_offset_y    (o_offset_y),
        .o_last        (o_last)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Low byte of an edge difference, read back as signed.
    function automatic int low_byte_signed(input int d);
        logic [7:0] b;
        b = d[7:0];
        return $signed(b);
    endfunction

    // Contact offset on one axis as seen from the box. Halving truncates toward zero,
    // which is what int division does.
    function automatic int contact_box_view(input int bl, input int br, input int rl,
                                            input int rr);
        int lo;
        int hi;
        lo = (bl > rl) ? bl : rl;
        hi = (br < rr) ? br : rr;
        if (lo == rl) begin
            return (hi == rr) ? low_byte_signed(br - bl) / 2 : low_byte_signed(rl - bl);
        end
        return (hi == rr) ? low_byte_signed(rr - bl) : low_byte_signed(br - bl) / 2;
    endfunction

    // Same, seen from the reference box.
    function automatic int contact_ref_view(input int bl, input int br, input int rl,
                                            input int rr);
        int lo;
        int hi;
        lo = (bl > rl) ? bl : rl;
        hi = (br < rr) ? br : rr;
        if (lo == rl) begin
            return (hi == rr) ? low_byte_signed(rr - rl) / 2 : low_byte_signed(br - rl);
        end
        return (hi == rr) ? low_byte_signed(bl - rl) : low_byte_signed(br - bl) / 2;
    endfunction

    function automatic void push_result(input logic [2:0] kind, input int slot, input int ox,
                                        input int oy, input logic last);
        result_t r;
        r.kind = kind;
        r.slot = 6'(slot);
        r.ox   = 8'(ox);
        r.oy   = 8'(oy);
        r.last = last;
        scan_results.push_back(r);
    endfunction

    // Applies one command to the shadow tables and leaves its words in scan_results.
    function automatic void apply_command(input cmd_word_t cw);
        logic [15:0] nr;
        logic [15:0] nb;
        int found;
        int bl, bt, br, bb;
        int rx, ry, rr, rb;
        scan_results.delete();
        // right and bottom wrap at 16 bits
        nr = cw.px + 16'(cw.size_w);
        nb = cw.py + 16'(cw.size_h);
        rx = cw.px;
        ry = cw.py;
        rr = cw.er;
        rb = cw.eb;
        case (cw.command)
            CMD_ALLOC: begin
                found = -1;
                for (int i = 0; i < SLOTS && found < 0; i++) begin
                    if (cw.sel == TBL_BOX) begin
                        // a box is free while right and bottom are both zero, so a
                        // zero-sized box is reported but the slot stays free
                        if (box_r[i] == '0 && box_b[i] == '0) begin
                            box_l[i] = cw.px;
                            box_t[i] = cw.py;
                            box_r[i] = nr;
                            box_b[i] = nb;
                            box_h[i] = cw.bh;
                            found = i;
                        end
                    end else if (!mark_used[i]) begin
                        mark_used[i] = (nr != '0) || (nb != '0);
                        found = i;
                    end
                end
                if (found >= 0) begin
                    push_result(KIND_ALLOC_OK, found, 0, 0, 1'b1);
                end else begin
                    push_result(KIND_FULL, 0, 0, 0, 1'b1);
                end
            end
            CMD_FREE: begin
                if (cw.sel == TBL_BOX) begin
                    box_l[cw.slot] = '0;
                    box_t[cw.slot] = '0;
                    box_r[cw.slot] = '0;
                    box_b[cw.slot] = '0;
                    box_h[cw.slot] = 1'b0;
                end else begin
                    mark_used[cw.slot] = 1'b0;
                end
                push_result(KIND_FREED, cw.slot, 0, 0, 1'b1);
            end
            CMD_TEST: begin
                // every slot is scanned, free ones too
                for (int i = 0; i < SLOTS; i++) begin
                    bl = $signed(box_l[i]);
                    bt = $signed(box_t[i]);
                    br = $signed(box_r[i]);
                    bb = $signed(box_b[i]);
                    if (br >= rx && bb >= ry && bl < rr && bt < rb) begin
                        if (box_h[i]) begin
                            push_result(KIND_BOX_HIT, i, contact_box_view(bl, br, rx, rr),
                                        contact_box_view(bt, bb, ry, rb), 1'b0);
                        end else if (cw.rh) begin
                            push_result(KIND_REF_HIT, i, contact_ref_view(bl, br, rx, rr),
                                        contact_ref_view(bt, bb, ry, rb), 1'b0);
                        end
                    end
                end
                if (scan_results.size() == 0) begin
                    push_result(KIND_NO_HIT, 0, 0, 0, 1'b1);
                end else begin
                    scan_results[scan_results.size() - 1].last = 1'b1;
                end
            end
            default: ;   // unused code: dropped, no word back
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_row(input logic [1:0] cmd, input logic sel, input int slot,
                                    input int px, input int py, input int sw, input int sh,
                                    input int er, input int eb, input logic bh,
                                    input logic rh, input int kind, input int slot_exp);
        plan_row_t row;
        row.cw.command = cmd;
        row.cw.sel     = sel;
        row.cw.slot    = 6'(slot);
        row.cw.px      = 16'(px);
        row.cw.py      = 16'(py);
        row.cw.size_w  = 15'(sw);
        row.cw.size_h  = 15'(sh);
        row.cw.er      = 16'(er);
        row.cw.eb      = 16'(eb);
        row.cw.bh      = bh;
        row.cw.rh      = rh;
        row.typed      = (kind != PREDICTED);
        row.kind       = 3'(kind);
        row.slot       = 6'(slot_exp);
        plan.push_back(row);
    endfunction

    // Random command. Most geometry sits in a small window so boxes overlap and offsets
    // stay near the 8-bit range; a quarter spans the full 16-bit range.
    function automatic cmd_word_t random_word(input bit filling);
        cmd_word_t cw;
        int pick;
        int s;
        pick = $urandom_range(99);
        if (pick < (filling ? 75 : 30)) begin
            cw.command = CMD_ALLOC;
        end else if (pick < (filling ? 80 : 60)) begin
            cw.command = CMD_FREE;
        end else if (pick < 96) begin
            cw.command = CMD_TEST;
        end else begin
            cw.command = CMD_UNUSED;
        end
        cw.sel  = 1'($urandom_range(1));
        cw.slot = 6'($urandom_range(SLOTS - 1));
        cw.bh   = 1'($urandom_range(1));
        cw.rh   = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
            cw.px     = 16'($urandom);
            cw.py     = 16'($urandom);
            cw.size_w = 15'($urandom);
            cw.size_h = 15'($urandom);
            cw.er     = 16'($urandom);
            cw.eb     = 16'($urandom);
        end else begin
            cw.px     = 16'($urandom_range(400) - 200);
            cw.py     = 16'($urandom_range(400) - 200);
            cw.size_w = 15'($urandom_range(300));
            cw.size_h = 15'($urandom_range(300));
            cw.er     = cw.px + 16'($urandom_range(300));
            cw.eb     = cw.py + 16'($urandom_range(300));
            if ($urandom_range(19) == 0) begin
                // zero-sized box: reported as allocated, slot stays free
                cw.px     = '0;
                cw.py     = '0;
                cw.size_w = '0;
                cw.size_h = '0;
            end
            if (cw.command == CMD_TEST && $urandom_range(3) == 0) begin
                // line one reference edge up with a stored edge to hit the
                // inclusive/exclusive boundaries
                s = $urandom_range(SLOTS - 1);
                case ($urandom_range(3))
                    0:       cw.px = box_r[s];
                    1:       cw.er = box_l[s];
                    2:       cw.py = box_b[s];
                    default: cw.eb = box_t[s];
                endcase
            end
        end
        return cw;
    endfunction

    // Offers one word, holds it until the block takes it, then records what it owes.
    task automatic send_word(input cmd_word_t cw, input bit typed, input result_t fixed);
        if (!steady_phase && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cw.command;
        i_table_sel   <= cw.sel;
        i_slot        <= cw.slot;
        i_pos_x       <= cw.px;
        i_pos_y       <= cw.py;
        i_size_w      <= cw.size_w;
        i_size_h      <= cw.size_h;
        i_edge_right  <= cw.er;
        i_edge_bottom <= cw.eb;
        i_box_handler <= cw.bh;
        i_ref_handler <= cw.rh;
        do @(posedge i_clk); while (o_stall);
        apply_command(cw);
        if (typed) begin
            awaited_words.push_back(fixed);
        end else begin
            foreach (scan_results[k]) awaited_words.push_back(scan_results[k]);
        end
    endtask

    initial begin
        result_t fixed;
        cmd_word_t cw;

        // Empty tables: nothing has a handler, so a plain reference sees no hit ...
        add_row(CMD_TEST, TBL_SPARE, 0, -32768, -32768, 0, 0, 32767, 32767, 0, 0,
                KIND_NO_HIT, 0);
        // ... but a reference with a handler hits all 64 free slots at once.
        add_row(CMD_TEST, TBL_SPARE, 0, -32768, -32768, 0, 0, 32767, 32767, 0, 1,
                PREDICTED, 0);
        add_row(CMD_ALLOC, TBL_BOX, 0, 10, 20, 30, 40, 0, 0, 1, 0, KIND_ALLOC_OK, 0);
        // extreme corner and sizes; bottom wraps to -2, below the top
        add_row(CMD_ALLOC, TBL_BOX, 0, -32768, 32767, 32767, 32767, 0, 0, 0, 0,
                KIND_ALLOC_OK, 1);
        // zero-sized box, then one whose edges wrap to zero: both land in slot 2
        add_row(CMD_ALLOC, TBL_BOX, 0, 0, 0, 0, 0, 0, 0, 1, 0, KIND_ALLOC_OK, 2);
        add_row(CMD_ALLOC, TBL_BOX, 0, -100, -1, 100, 1, 0, 0, 1, 0, KIND_ALLOC_OK, 2);
        // unchecked table: the zero-sized mark leaves slot 1 clear
        add_row(CMD_ALLOC, TBL_SPARE, 0, 5, 0, 1, 0, 0, 0, 0, 0, KIND_ALLOC_OK, 0);
        add_row(CMD_ALLOC, TBL_SPARE, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_ALLOC_OK, 1);
        add_row(CMD_ALLOC, TBL_SPARE, 0, -32768, -32768, 32767, 32767, 0, 0, 0, 0,
                KIND_ALLOC_OK, 1);
        add_row(CMD_FREE, TBL_SPARE, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_FREED, 0);
        add_row(CMD_FREE, TBL_BOX, 63, 0, 0, 0, 0, 0, 0, 0, 0, KIND_FREED, 63);
        // box hits, including the free slot that kept its handler
        add_row(CMD_TEST, TBL_SPARE, 0, 0, 0, 0, 0, 50, 50, 0, 0, PREDICTED, 0);
        add_row(CMD_TEST, TBL_SPARE, 0, 20, 30, 0, 0, 100, 45, 0, 1, PREDICTED, 0);
        // reference left/top on the box's right/bottom: still a hit
        add_row(CMD_TEST, TBL_SPARE, 0, 40, 60, 0, 0, 41, 61, 0, 0, PREDICTED, 0);
        // reference right on the box's left: no hit for that box
        add_row(CMD_TEST, TBL_SPARE, 0, -5, -5, 0, 0, 10, 20, 0, 0, PREDICTED, 0);
        add_row(CMD_UNUSED, TBL_BOX, 7, 1, 2, 3, 4, 5, 6, 1, 1, PREDICTED, 0);
        add_row(CMD_FREE, TBL_BOX, 2, 0, 0, 0, 0, 0, 0, 0, 0, KIND_FREED, 2);
        // 300-wide box: differences overflow 8 bits before halving
        add_row(CMD_ALLOC, TBL_BOX, 0, -150, -150, 300, 300, 0, 0, 1, 0, KIND_ALLOC_OK, 2);
        add_row(CMD_TEST, TBL_SPARE, 0, -140, -20, 0, 0, 140, 200, 0, 1, PREDICTED, 0);
        add_row(CMD_TEST, TBL_SPARE, 0, -300, -300, 0, 0, 300, 300, 0, 0, PREDICTED, 0);
        add_row(CMD_TEST, TBL_SPARE, 0, 100, -200, 0, 0, 400, -100, 0, 1, PREDICTED, 0);
        // inverted reference spanning the extremes cannot hit anything
        add_row(CMD_TEST, TBL_SPARE, 0, 32767, 32767, 0, 0, -32768, -32768, 0, 1,
                KIND_NO_HIT, 0);
        // box without handler: silent unless the reference has one
        add_row(CMD_ALLOC, TBL_BOX, 0, -20, -20, 10, 10, 0, 0, 0, 0, KIND_ALLOC_OK, 3);
        add_row(CMD_TEST, TBL_SPARE, 0, -25, -25, 0, 0, -15, -15, 0, 0, PREDICTED, 0);
        add_row(CMD_TEST, TBL_SPARE, 0, -25, -25, 0, 0, -15, -15, 0, 1, PREDICTED, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            fixed.kind = plan[k].kind;
            fixed.slot = plan[k].slot;
            fixed.ox   = '0;
            fixed.oy   = '0;
            fixed.last = 1'b1;
            send_word(plan[k].cw, plan[k].typed, fixed);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == STEADY_FROM) steady_phase = 1'b1;
            cw = random_word(n < FILL_WORDS);
            send_word(cw, 1'b0, fixed);
        end
        i_valid <= 1'b0;

        // drain, then give a stray word a full scan's time to show up
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 20) @(posedge i_clk);
        if (fail_count == 0 && awaited_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Output-side stall: random bursts, one long hold-off on request so the block
    // backs up into its input, none at all in the closing stretch.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (steady_phase) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(2) == 0);
                repeat ($urandom_range(15, 1)) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_words.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("%0t: unexpected word kind %0d slot %0d x %0d y %0d last %0d",
                             $time, o_kind, o_slot_index, o_offset_x, o_offset_y, o_last);
                end
                fail_count++;
            end else begin
                want = awaited_words.pop_front();
                if (o_kind !== want.kind || o_slot_index !== want.slot ||
                    o_offset_x !== want.ox || o_offset_y !== want.oy ||
                    o_last !== want.last) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: expected kind %0d slot %0d x %0d y %0d last %0d",
                                 $time, want.kind, want.slot, want.ox, want.oy, want.last);
                        $display("%0t:      got kind %0d slot %0d x %0d y %0d last %0d",
                                 $time, o_kind, o_slot_index, o_offset_x, o_offset_y,
                                 o_last);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a run where neither side moves for too long is hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
